FILE: rtl/cpfv_pkg.sv
// Package for the CPF check digit validator: types, constants and the mod-11 helper.
package cpfv_pkg;

  // Default depths of the queue between the two halves and of the result queue
  localparam int unsigned MidDepth = 2;
  localparam int unsigned ResDepth = 2;

  // Digit range and counts
  localparam logic [7:0] AsciiZero  = 8'h30;
  localparam logic [7:0] AsciiNine  = 8'h39;
  localparam logic [3:0] CpfLength  = 4'd11;
  localparam logic [3:0] CountSat   = 4'd12;
  localparam logic [3:0] TenthPos   = 4'd9;
  localparam logic [3:0] EleventhPos = 4'd10;

  typedef enum logic [2:0] {
    ReasonOk       = 3'd0,
    ReasonLength   = 3'd1,
    ReasonAllEqual = 3'd2,
    ReasonFirstBad = 3'd3,
    ReasonSecondBad = 3'd4
  } reason_e;

  // One classified character as it travels from front to back
  typedef struct packed {
    logic       is_digit;
    logic [3:0] value;
    logic       last;
  } item_t;

  // One result word
  typedef struct packed {
    logic    valid;
    reason_e reason;
  } result_t;

  // Expected check digit: (s*10) mod 11 with 10 mapped to 0, i.e. (-s) mod 11
  function automatic logic [3:0] check_digit(input logic [9:0] s);
    logic [20:0] prod;
    logic [6:0]  quot;
    logic [10:0] rem;
    logic [3:0]  r4;
    begin
      // quotient by reciprocal 2^14/11, corrected by one compare and subtract
      prod = 21'(s) * 21'd1490;
      quot = prod[20:14];
      rem  = {1'b0, s} - (11'(quot) * 11'd11);
      if (rem >= 11'd11) begin
        rem = rem - 11'd11;
      end
      r4 = rem[3:0];
      if (r4 <= 4'd1) begin
        check_digit = 4'd0;
      end else begin
        check_digit = 4'd11 - r4;
      end
    end
  endfunction

endpackage

FILE: rtl/cpf_check_digit_validator.sv
// CPF check digit validator: front classifier, word queue, back accumulator, result queue.
// Throughput: one character per cycle while neither queue is full.
// Path: the last character passes through the word queue, is folded with the state into
// the snapshot, and its check is written into the result queue that drives the result ports.
// Reset: rst_ni clears queue pointers, the digit state and the snapshot's valid flag at once.
// The front stalls only when the word queue is full; the back only on a full result queue.
module cpf_check_digit_validator import cpfv_pkg::*; #(
  parameter int unsigned MidQDepth = MidDepth,
  parameter int unsigned ResQDepth = ResDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] char_in_i,
  input  logic       last_char_i,
  input  logic       pop,
  output logic       empty,
  output logic       valid_res_o,
  output logic [2:0] reason_o
);

  item_t   front_item, back_item;
  result_t back_res, out_res;
  logic    q_empty, q_pop, res_push, res_full;

  cpfv_front u_front (
    .char_in_i   (char_in_i),
    .last_char_i (last_char_i),
    .item_o      (front_item)
  );

  cpfv_fifo #(
    .Depth (MidQDepth),
    .Width ($bits(item_t))
  ) u_mid_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (push),
    .wdata_i (front_item),
    .full_o  (full),
    .rd_i    (q_pop),
    .rdata_o (back_item),
    .empty_o (q_empty)
  );

  cpfv_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (back_item),
    .item_empty_i (q_empty),
    .item_pop_o   (q_pop),
    .res_full_i   (res_full),
    .res_push_o   (res_push),
    .res_o        (back_res)
  );

  cpfv_fifo #(
    .Depth (ResQDepth),
    .Width ($bits(result_t))
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (res_push),
    .wdata_i (back_res),
    .full_o  (res_full),
    .rd_i    (pop),
    .rdata_o (out_res),
    .empty_o (empty)
  );

  assign valid_res_o = out_res.valid;
  assign reason_o    = out_res.reason;

  // Back never takes a word from an empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_pop |-> !q_empty)
    else $error("word taken from empty queue");

  // Back never pushes a result into a full result queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) res_push |-> !res_full)
    else $error("result pushed into full queue");

  // A shown result is consistent: valid exactly when the reason is ok
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (valid_res_o == (reason_o == ReasonOk)))
    else $error("valid flag disagrees with reason");

  // A pushed result carries a defined reason code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> (back_res.reason == ReasonOk || back_res.reason == ReasonLength ||
                  back_res.reason == ReasonAllEqual || back_res.reason == ReasonFirstBad ||
                  back_res.reason == ReasonSecondBad))
    else $error("undefined reason code pushed");

endmodule

FILE: rtl/cpfv_fifo.sv
// Small register queue used between the halves and on the result side.
module cpfv_fifo #(
  parameter int unsigned Depth = 2,
  parameter int unsigned Width = 6
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             rd_i,
  output logic [Width-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_wr, do_rd;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  // Advance pointers and count
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_wr) begin
      wptr_d = (wptr_q == LastPtr) ? '0 : wptr_q + 1'b1;
    end
    if (do_rd) begin
      rptr_d = (rptr_q == LastPtr) ? '0 : rptr_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Store the incoming word
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

FILE: rtl/cpfv_front.sv
// Front half: classifies each incoming character as digit or skipped.
module cpfv_front import cpfv_pkg::*; (
  input  logic [7:0] char_in_i,
  input  logic       last_char_i,
  output item_t      item_o
);

  logic [7:0] offset;

  assign offset = char_in_i - AsciiZero;

  // Tag digits and strip the ASCII offset
  always_comb begin
    item_o.is_digit = (char_in_i >= AsciiZero) && (char_in_i <= AsciiNine);
    item_o.value    = offset[3:0];
    item_o.last     = last_char_i;
  end

endmodule

FILE: rtl/cpfv_back.sv
// Back half: accumulates digit state and checks the identifier on its last word.
module cpfv_back import cpfv_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  item_t   item_i,
  input  logic    item_empty_i,
  output logic    item_pop_o,
  input  logic    res_full_i,
  output logic    res_push_o,
  output result_t res_o
);

  // Live string state
  logic [3:0] count_q, count_d;
  logic [3:0] lead_q, lead_d;
  logic       equal_q, equal_d;
  logic [8:0] sum9_q, sum9_d;
  logic [9:0] sum10_q, sum10_d;
  logic [3:0] d10_q, d10_d;
  logic [3:0] d11_q, d11_d;

  // Snapshot of a finished string, checked combinationally and held until the result queue takes it
  logic       fin_valid_q, fin_valid_d;
  logic [3:0] fin_count_q;
  logic       fin_equal_q;
  logic [8:0] fin_sum9_q;
  logic [9:0] fin_sum10_q;
  logic [3:0] fin_d10_q;
  logic [3:0] fin_d11_q;

  // Updated values before the end-of-string clear
  logic [3:0] up_count, up_lead, up_d10, up_d11;
  logic       up_equal;
  logic [8:0] up_sum9;
  logic [9:0] up_sum10;
  logic [7:0] prod9, prod10;

  logic fin_drain, take, take_last;

  assign fin_drain  = fin_valid_q && !res_full_i;
  assign take       = !item_empty_i && (!item_i.last || !fin_valid_q || fin_drain);
  assign take_last  = take && item_i.last;
  assign item_pop_o = take;
  assign res_push_o = fin_drain;

  assign prod9  = item_i.value * (4'd10 - count_q);
  assign prod10 = item_i.value * (4'd11 - count_q);

  // Fold one digit into the string state
  always_comb begin
    up_count = count_q;
    up_lead  = lead_q;
    up_equal = equal_q;
    up_sum9  = sum9_q;
    up_sum10 = sum10_q;
    up_d10   = d10_q;
    up_d11   = d11_q;
    if (item_i.is_digit) begin
      if (count_q == '0) begin
        up_lead = item_i.value;
      end else if (count_q < CpfLength && item_i.value != lead_q) begin
        up_equal = 1'b0;
      end
      if (count_q < TenthPos) begin
        up_sum9 = sum9_q + 9'(prod9);
      end
      if (count_q < EleventhPos) begin
        up_sum10 = sum10_q + 10'(prod10);
      end
      if (count_q == TenthPos) begin
        up_d10 = item_i.value;
      end
      if (count_q == EleventhPos) begin
        up_d11 = item_i.value;
      end
      if (count_q < CountSat) begin
        up_count = count_q + 4'd1;
      end
    end
  end

  // Hold state, advance on a taken word, clear after the last one
  always_comb begin
    count_d = count_q;
    lead_d  = lead_q;
    equal_d = equal_q;
    sum9_d  = sum9_q;
    sum10_d = sum10_q;
    d10_d   = d10_q;
    d11_d   = d11_q;
    if (take_last) begin
      count_d = '0;
      lead_d  = '0;
      equal_d = 1'b1;
      sum9_d  = '0;
      sum10_d = '0;
      d10_d   = '0;
      d11_d   = '0;
    end else if (take) begin
      count_d = up_count;
      lead_d  = up_lead;
      equal_d = up_equal;
      sum9_d  = up_sum9;
      sum10_d = up_sum10;
      d10_d   = up_d10;
      d11_d   = up_d11;
    end
    fin_valid_d = take_last ? 1'b1 : (fin_drain ? 1'b0 : fin_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      lead_q      <= '0;
      equal_q     <= 1'b1;
      sum9_q      <= '0;
      sum10_q     <= '0;
      d10_q       <= '0;
      d11_q       <= '0;
      fin_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      lead_q      <= lead_d;
      equal_q     <= equal_d;
      sum9_q      <= sum9_d;
      sum10_q     <= sum10_d;
      d10_q       <= d10_d;
      d11_q       <= d11_d;
      fin_valid_q <= fin_valid_d;
    end
  end

  // Capture the finished string
  always_ff @(posedge clk_i) begin
    if (take_last) begin
      fin_count_q <= up_count;
      fin_equal_q <= up_equal;
      fin_sum9_q  <= up_sum9;
      fin_sum10_q <= up_sum10;
      fin_d10_q   <= up_d10;
      fin_d11_q   <= up_d11;
    end
  end

  // Check in order: length, all equal, first and second check digit
  always_comb begin
    priority if (fin_count_q != CpfLength) begin
      res_o.reason = ReasonLength;
    end else if (fin_equal_q) begin
      res_o.reason = ReasonAllEqual;
    end else if (check_digit({1'b0, fin_sum9_q}) != fin_d10_q) begin
      res_o.reason = ReasonFirstBad;
    end else if (check_digit(fin_sum10_q) != fin_d11_q) begin
      res_o.reason = ReasonSecondBad;
    end else begin
      res_o.reason = ReasonOk;
    end
    res_o.valid = (res_o.reason == ReasonOk);
  end

endmodule
